// ===== rtl/pbrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pbrb_pkg;

  localparam int STORE_BYTES_DEF     = 1024;
  localparam int BLOCK_SLOTS_DEF     = 8;
  localparam int MAX_BLOCK_BYTES_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DESC   = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/pbrb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pbrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/packet_block_ring_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Packet FIFO with a descriptor ring. A write item (store one byte, unless the
// block holds MAX_BLOCK_BYTES) and a clear item leave busy low; the next item
// can start in the following cycle. A read item of an empty buffer also leaves
// busy low and puts one empty result on the outputs in the next cycle. A read
// item of a stored block holds busy high once accepted: ST_DESC takes its
// descriptor and issues the first byte memory read, then ST_STREAM does one
// byte memory read per cycle. Results appear from the cycle after ST_DESC, one
// byte per cycle, each for exactly one cycle with out_valid high. The receiver
// cannot stall; it must take every result in the cycle it is shown.
module packet_block_ring_buffer_core
  import pbrb_pkg::*;
#(
  parameter int STORE_BYTES     = STORE_BYTES_DEF,
  parameter int BLOCK_SLOTS     = BLOCK_SLOTS_DEF,
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  output logic      [BYTE_W-1:0] out_byte,
  output logic      [LEN_W-1:0]  out_block_length,
  output logic                   out_last,
  output logic                   out_empty_res
);

  localparam int IDX_W  = $clog2(STORE_BYTES);
  localparam int FILL_W = $clog2(STORE_BYTES + 1);
  localparam int SLOT_W = $clog2(BLOCK_SLOTS);
  localparam int CNT_W  = $clog2(BLOCK_SLOTS + 1);
  localparam int DESC_W = IDX_W + LEN_W;

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0]  bic_r, bic_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  issued_r, issued_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic              byte_we;
  logic [IDX_W-1:0]  byte_waddr;
  logic [IDX_W-1:0]  byte_raddr;
  logic [BYTE_W-1:0] byte_rdata;
  logic              desc_we;
  logic [DESC_W-1:0] desc_wdata;
  logic [DESC_W-1:0] desc_rdata;

  logic              accept;
  logic              wrap;
  logic              wr_keep;
  logic [FILL_W-1:0] fill_eff;
  logic [FILL_W-1:0] fill_new;
  logic [LEN_W-1:0]  bic_new;
  logic [IDX_W-1:0]  blk_start;
  logic [IDX_W-1:0]  desc_start;
  logic [LEN_W-1:0]  desc_len;
  logic [SLOT_W-1:0] ws_inc;
  logic [SLOT_W-1:0] rs_inc;

  assign accept     = start && (state_r == ST_IDLE);
  assign wrap       = (bic_r == '0) && (fill_r > FILL_W'(STORE_BYTES - MAX_BLOCK_BYTES));
  assign fill_eff   = wrap ? '0 : fill_r;
  assign wr_keep    = bic_r < LEN_W'(MAX_BLOCK_BYTES);
  assign fill_new   = fill_eff + FILL_W'(wr_keep);
  assign bic_new    = bic_r + LEN_W'(wr_keep);
  assign blk_start  = fill_new[IDX_W-1:0] - IDX_W'(bic_new);
  assign desc_start = desc_rdata[DESC_W-1:LEN_W];
  assign desc_len   = desc_rdata[LEN_W-1:0];
  assign ws_inc     = (write_slot_r == SLOT_W'(BLOCK_SLOTS - 1)) ? '0 : write_slot_r + 1'b1;
  assign rs_inc     = (read_slot_r == SLOT_W'(BLOCK_SLOTS - 1)) ? '0 : read_slot_r + 1'b1;

  assign byte_we    = accept && (in_kind == KIND_WRITE) && wr_keep;
  assign byte_waddr = fill_eff[IDX_W-1:0];
  assign byte_raddr = (state_r == ST_DESC) ? desc_start : ptr_r;
  assign desc_we    = accept && (in_kind == KIND_WRITE) && in_last_byte;
  assign desc_wdata = {blk_start, bic_new};

  pbrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (in_byte),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  pbrb_ram #(
    .WIDTH (DESC_W),
    .DEPTH (BLOCK_SLOTS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (write_slot_r),
    .wdata (desc_wdata),
    .raddr (read_slot_r),
    .rdata (desc_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    read_slot_nxt  = read_slot_r;
    write_slot_nxt = write_slot_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    bic_nxt        = bic_r;
    ptr_nxt        = ptr_r;
    issued_nxt     = issued_r;
    len_nxt        = len_r;
    out_valid_nxt  = 1'b0;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_WRITE: begin
              fill_nxt = fill_new;
              bic_nxt  = bic_new;
              if (in_last_byte) begin
                write_slot_nxt = ws_inc;
                bic_nxt        = '0;
                if (count_r < CNT_W'(BLOCK_SLOTS)) begin
                  count_nxt = count_r + 1'b1;
                end else begin
                  read_slot_nxt = rs_inc;
                end
              end
            end
            KIND_READ: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_len_nxt   = '0;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
              end else begin
                state_nxt = ST_DESC;
              end
            end
            KIND_CLEAR: begin
              read_slot_nxt  = '0;
              write_slot_nxt = '0;
              count_nxt      = '0;
              fill_nxt       = '0;
              bic_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DESC: begin
        read_slot_nxt = rs_inc;
        count_nxt     = count_r - 1'b1;
        ptr_nxt       = desc_start + 1'b1;
        issued_nxt    = LEN_W'(1);
        len_nxt       = desc_len;
        out_valid_nxt = 1'b1;
        out_len_nxt   = desc_len;
        out_last_nxt  = (desc_len == LEN_W'(1));
        out_empty_nxt = 1'b0;
        state_nxt     = (desc_len == LEN_W'(1)) ? ST_IDLE : ST_STREAM;
      end
      ST_STREAM: begin
        ptr_nxt       = ptr_r + 1'b1;
        issued_nxt    = issued_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (issued_r + 1'b1 == len_r);
        if (issued_r + 1'b1 == len_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_slot_r  <= '0;
      write_slot_r <= '0;
      count_r      <= '0;
      fill_r       <= '0;
      bic_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_slot_r  <= read_slot_nxt;
      write_slot_r <= write_slot_nxt;
      count_r      <= count_nxt;
      fill_r       <= fill_nxt;
      bic_r        <= bic_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    issued_r    <= issued_nxt;
    len_r       <= len_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_byte         = out_empty_r ? '0 : byte_rdata;
  assign out_block_length = out_len_r;
  assign out_last         = out_last_r;
  assign out_empty_res    = out_empty_r;

endmodule
`default_nettype wire
